// ===== hdl/slrf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slrf_pkg
// Shared types and constants for the serial display rectangle-fill sequencer.
// ----------------------------------------------------------------------------
package slrf_pkg;

  localparam int COORD_BITS = 10;
  localparam int ADDR_BITS  = 16;
  localparam int PIX_BITS   = 2 * COORD_BITS;
  localparam int COLOR_BITS = 16;
  localparam int BYTE_BITS  = 8;
  localparam int BIT_BITS   = 3;

  localparam logic [BYTE_BITS-1:0] CMD_COL      = 8'h2A;
  localparam logic [BYTE_BITS-1:0] CMD_ROW      = 8'h2B;
  localparam logic [BYTE_BITS-1:0] CMD_MEM      = 8'h2C;
  localparam logic [BYTE_BITS-1:0] OFFSET_RESET = 8'd34;
  localparam logic [1:0]           LAST_ADDR_BYTE = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CMD_COL = 3'd1,
    PH_COL     = 3'd2,
    PH_CMD_ROW = 3'd3,
    PH_ROW     = 3'd4,
    PH_CMD_MEM = 3'd5,
    PH_PIX     = 3'd6
  } phase_t;

  typedef struct packed {
    logic serial_bit;
    logic clocked;
    logic data_not_command;
    logic select_active;
    logic byte_last;
    logic frame_last;
    logic busy_res;
    logic rejected;
  } res_t;

endpackage : slrf_pkg
`default_nettype wire

// ===== hdl/spi_lcd_rect_fill_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spi_lcd_rect_fill_sequencer
// Turns a rectangle fill request into the bit stream of a serial display link:
// column/row address windows, memory write command and the pixel run.
// ----------------------------------------------------------------------------
// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------------------
// in       | in_valid / in_stall  | req_type, x_start, y_start, rect_width,
//          |                      | rect_height, fill_color
// out      | out_valid / out_stall| serial_bit, clocked, data_not_command,
//          |                      | select_active, byte_last, frame_last,
//          |                      | busy_res, rejected
// cfg      | cfg_wr_en            | cfg_wr_data (row_offset)
//
// One item per cycle while in_stall is low: each item taken yields one registered result.
// The bit slot logic sits between the sequencer state and the result register.
// A two-entry output (result register plus skid register) keeps input taking
// while one result waits; in_stall rises only when both are full.
// Reset (rst, synchronous) returns to idle with row_offset at 34.
// ----------------------------------------------------------------------------
module spi_lcd_rect_fill_sequencer
  import slrf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  req_type,
  input  wire logic [COORD_BITS-1:0] x_start,
  input  wire logic [COORD_BITS-1:0] y_start,
  input  wire logic [COORD_BITS-1:0] rect_width,
  input  wire logic [COORD_BITS-1:0] rect_height,
  input  wire logic [COLOR_BITS-1:0] fill_color,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       serial_bit,
  output logic                       clocked,
  output logic                       data_not_command,
  output logic                       select_active,
  output logic                       byte_last,
  output logic                       frame_last,
  output logic                       busy_res,
  output logic                       rejected,
  input  wire logic                  cfg_wr_en,
  input  wire logic [BYTE_BITS-1:0]  cfg_wr_data
);

  // sequencer state
  phase_t                phase, phase_next;
  logic [1:0]            byte_in_frame, byte_in_frame_next;
  logic [BIT_BITS-1:0]   bit_position, bit_position_next;
  logic [PIX_BITS-1:0]   pixels_left, pixels_left_next;
  logic                  high_byte, high_byte_next;
  logic [COORD_BITS-1:0] latched_x, latched_y, latched_w, latched_h;
  logic [COLOR_BITS-1:0] latched_color;
  logic [BYTE_BITS-1:0]  row_offset;

  // output side
  res_t res_next, out_res, skid_res;
  logic skid_valid;

  logic                 in_take, out_take;
  logic [ADDR_BITS-1:0] col_start, col_end, row_start, row_end;
  logic [BYTE_BITS-1:0] cur_byte;
  logic                 is_cmd, blast, flast;
  logic [PIX_BITS-1:0]  pix_dec;

  assign in_stall = skid_valid;
  assign in_take  = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  // address window and the byte in flight
  always_comb begin
    logic [ADDR_BITS-1:0] sel;
    col_start = ADDR_BITS'(latched_x);
    col_end   = col_start + ADDR_BITS'(latched_w) - ADDR_BITS'(1);
    row_start = ADDR_BITS'(latched_y) + ADDR_BITS'(row_offset);
    row_end   = row_start + ADDR_BITS'(latched_h) - ADDR_BITS'(1);
    sel       = '0;
    case (phase)
      PH_CMD_COL: cur_byte = CMD_COL;
      PH_CMD_ROW: cur_byte = CMD_ROW;
      PH_CMD_MEM: cur_byte = CMD_MEM;
      PH_COL: begin
        sel      = byte_in_frame[1] ? col_end : col_start;
        cur_byte = byte_in_frame[0] ? sel[7:0] : sel[15:8];
      end
      PH_ROW: begin
        sel      = byte_in_frame[1] ? row_end : row_start;
        cur_byte = byte_in_frame[0] ? sel[7:0] : sel[15:8];
      end
      default: cur_byte = high_byte ? latched_color[15:8] : latched_color[7:0];
    endcase
  end

  assign is_cmd  = (phase == PH_CMD_COL) || (phase == PH_CMD_ROW) || (phase == PH_CMD_MEM);
  assign blast   = (bit_position == '0);
  assign pix_dec = (pixels_left != '0) ? pixels_left - PIX_BITS'(1) : '0;

  // next state
  always_comb begin
    phase_next         = phase;
    byte_in_frame_next = byte_in_frame;
    bit_position_next  = bit_position;
    pixels_left_next   = pixels_left;
    high_byte_next     = high_byte;
    flast              = 1'b0;
    if (req_type) begin
      if (phase == PH_IDLE) begin
        phase_next         = PH_CMD_COL;
        byte_in_frame_next = '0;
        bit_position_next  = '1;
        high_byte_next     = 1'b1;
        pixels_left_next   = PIX_BITS'(rect_width) * PIX_BITS'(rect_height);
      end
    end else if (phase != PH_IDLE) begin
      if (!blast) begin
        bit_position_next = bit_position - BIT_BITS'(1);
      end else begin
        bit_position_next = '1;
        case (phase)
          PH_CMD_COL: begin
            flast              = 1'b1;
            phase_next         = PH_COL;
            byte_in_frame_next = '0;
          end
          PH_CMD_ROW: begin
            flast              = 1'b1;
            phase_next         = PH_ROW;
            byte_in_frame_next = '0;
          end
          PH_COL, PH_ROW: begin
            if (byte_in_frame == LAST_ADDR_BYTE) begin
              flast              = 1'b1;
              phase_next         = (phase == PH_COL) ? PH_CMD_ROW : PH_CMD_MEM;
              byte_in_frame_next = '0;
            end else begin
              byte_in_frame_next = byte_in_frame + 2'd1;
            end
          end
          PH_CMD_MEM: begin
            flast              = 1'b1;
            byte_in_frame_next = '0;
            high_byte_next     = 1'b1;
            // skip an empty pixel frame
            phase_next         = (pixels_left == '0) ? PH_IDLE : PH_PIX;
          end
          PH_PIX: begin
            if (high_byte) begin
              high_byte_next = 1'b0;
            end else begin
              high_byte_next   = 1'b1;
              pixels_left_next = pix_dec;
              if (pix_dec == '0) begin
                flast      = 1'b1;
                phase_next = PH_IDLE;
              end
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // result of this item
  always_comb begin
    res_next = '0;
    if (req_type) begin
      res_next.busy_res = 1'b1;
      res_next.rejected = (phase != PH_IDLE);
    end else if (phase != PH_IDLE) begin
      res_next.serial_bit       = cur_byte[bit_position];
      res_next.clocked          = 1'b1;
      res_next.data_not_command = !is_cmd;
      res_next.select_active    = 1'b1;
      res_next.byte_last        = blast;
      res_next.frame_last       = flast;
      res_next.busy_res         = (phase_next != PH_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_in_frame <= '0;
      bit_position  <= '1;
      pixels_left   <= '0;
      high_byte     <= 1'b1;
      row_offset    <= OFFSET_RESET;
    end else begin
      if (cfg_wr_en) begin
        row_offset <= cfg_wr_data;
      end
      if (in_take) begin
        phase         <= phase_next;
        byte_in_frame <= byte_in_frame_next;
        bit_position  <= bit_position_next;
        pixels_left   <= pixels_left_next;
        high_byte     <= high_byte_next;
      end
    end
  end

  // rectangle is latched only by an accepted start
  always_ff @(posedge clk) begin
    if (in_take && req_type && (phase == PH_IDLE)) begin
      latched_x     <= x_start;
      latched_y     <= y_start;
      latched_w     <= rect_width;
      latched_h     <= rect_height;
      latched_color <= fill_color;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (in_take) begin
        if (out_valid && !out_take) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_res <= skid_res;
      end
    end else if (in_take) begin
      if (out_valid && !out_take) begin
        skid_res <= res_next;
      end else begin
        out_res <= res_next;
      end
    end
  end

  assign serial_bit       = out_res.serial_bit;
  assign clocked          = out_res.clocked;
  assign data_not_command = out_res.data_not_command;
  assign select_active    = out_res.select_active;
  assign byte_last        = out_res.byte_last;
  assign frame_last       = out_res.frame_last;
  assign busy_res         = out_res.busy_res;
  assign rejected         = out_res.rejected;

endmodule : spi_lcd_rect_fill_sequencer
`default_nettype wire

// ===== hdl/slrf_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slrf_checker
// Port-level checks for the rectangle-fill sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module slrf_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic serial_bit,
  input wire logic clocked,
  input wire logic data_not_command,
  input wire logic select_active,
  input wire logic byte_last,
  input wire logic frame_last,
  input wire logic busy_res,
  input wire logic rejected
);

  // the input stalls only when a result is already waiting
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("input stalled with no result held");

  // a held result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(serial_bit) && $stable(clocked)
      && $stable(frame_last) && $stable(busy_res) && $stable(rejected))
    else $error("stalled result changed");

  // a rejected start uses no bit slot and reports busy
  assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> busy_res && !clocked && !select_active)
    else $error("rejected start clocked a bit");

  // a frame ends only at a byte boundary of a clocked bit
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> byte_last && clocked && select_active)
    else $error("frame ended mid-byte");

  // nothing on the data line outside a clocked slot
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !clocked |-> !serial_bit && !data_not_command && !byte_last)
    else $error("data driven in an idle slot");

endmodule : slrf_checker

bind spi_lcd_rect_fill_sequencer slrf_checker u_slrf_checker (
  .clk              (clk),
  .rst              (rst),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .serial_bit       (serial_bit),
  .clocked          (clocked),
  .data_not_command (data_not_command),
  .select_active    (select_active),
  .byte_last        (byte_last),
  .frame_last       (frame_last),
  .busy_res         (busy_res),
  .rejected         (rejected)
);
`default_nettype wire
